// ===== design/hmc_pkg.sv =====
// Shared constants and types for the half-pel motion compensation predictor.
`timescale 1ns / 1ps
package hmc_pkg;

  localparam int unsigned LANES                = 8;
  localparam int unsigned PIX_W                = 8;
  localparam int unsigned SEG_W                = LANES * PIX_W;
  localparam int unsigned ROW_W                = (LANES + 1) * PIX_W;
  localparam int unsigned SEGMENTS_PER_ROW_DEF = 2;

  typedef struct packed {
    logic half_x;
    logic half_y;
    logic average_mode;
    logic segment;
    logic first_row;
    logic last_row;
  } hmc_ctl_t;

  typedef struct packed {
    logic     valid;
    hmc_ctl_t ctl;
  } hmc_stage_t;

endpackage

// ===== design/hmc_line_store.sv =====
// Previous-row store: synchronous memory, read-first, with registered read data.
`timescale 1ns / 1ps
module hmc_line_store import hmc_pkg::*; #(
  parameter int unsigned DEPTH  = SEGMENTS_PER_ROW_DEF,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              en,
  input  logic [ADDR_W-1:0] addr,
  input  logic [ROW_W-1:0]  wdata,
  output logic [ROW_W-1:0]  rdata
);

  logic [ROW_W-1:0] mem [DEPTH];
  logic [ROW_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rdata_r   <= mem[addr];
      mem[addr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/hmc_interp.sv =====
// Per-lane half-pel interpolation, averaging and the output register.
`timescale 1ns / 1ps
module hmc_interp import hmc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  hmc_stage_t       s1,
  input  logic [ROW_W-1:0] cur_row,
  input  logic [ROW_W-1:0] up_row,
  input  logic [SEG_W-1:0] prior,
  output logic             s1_free,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [SEG_W-1:0] out_predicted_pixels,
  output logic             out_segment,
  output logic             out_block_done
);

  logic             out_valid_r, out_valid_nxt;
  logic [SEG_W-1:0] pix_r, pix_nxt;
  logic             seg_r, done_r;
  logic             ready, drop, take;

  assign ready   = !out_valid_r || !out_stall;
  assign drop    = s1.ctl.half_y && s1.ctl.first_row;
  assign take    = s1.valid && !drop && ready;
  assign s1_free = !s1.valid || drop || ready;

  always_comb begin
    logic [PIX_W-1:0] a, b, u, v, d, p;
    logic [PIX_W+1:0] s;
    pix_nxt = '0;
    for (int i = 0; i < LANES; i++) begin
      a = cur_row[i*PIX_W +: PIX_W];
      b = cur_row[(i+1)*PIX_W +: PIX_W];
      u = up_row[i*PIX_W +: PIX_W];
      v = up_row[(i+1)*PIX_W +: PIX_W];
      d = prior[i*PIX_W +: PIX_W];
      s = '0;
      priority if (s1.ctl.half_x && s1.ctl.half_y) begin
        s = {2'b00, a} + {2'b00, b} + {2'b00, u} + {2'b00, v} + (PIX_W+2)'(2);
        p = s[PIX_W+1:2];
      end else if (s1.ctl.half_y) begin
        s = {2'b00, u} + {2'b00, a} + (PIX_W+2)'(1);
        p = s[PIX_W:1];
      end else if (s1.ctl.half_x) begin
        s = {2'b00, a} + {2'b00, b} + (PIX_W+2)'(1);
        p = s[PIX_W:1];
      end else begin
        p = a;
      end
      if (s1.ctl.average_mode) begin
        s = {2'b00, p} + {2'b00, d} + (PIX_W+2)'(1);
        p = s[PIX_W:1];
      end
      pix_nxt[i*PIX_W +: PIX_W] = p;
    end
  end

  always_comb begin
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pix_r  <= pix_nxt;
      seg_r  <= s1.ctl.segment;
      done_r <= s1.ctl.last_row;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_predicted_pixels = pix_r;
  assign out_segment          = seg_r;
  assign out_block_done       = done_r;

endmodule

// ===== design/halfpel_motion_comp_predict.sv =====
// Top level of the half-pel motion compensation predictor.
// An accepted transaction is registered in stage 1 and then in the output register.
// One segment per cycle if unstalled; each transaction reads and writes the line store once.
// A vertical first-row transaction only fills the line store and yields no result.
// Reset clears the pipeline valid flags; the line store is not cleared.
`timescale 1ns / 1ps
module halfpel_motion_comp_predict import hmc_pkg::*; #(
  parameter int unsigned SEGMENTS_PER_ROW = SEGMENTS_PER_ROW_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [SEG_W-1:0] in_ref_pixels,
  input  logic [PIX_W-1:0] in_ref_right,
  input  logic [SEG_W-1:0] in_prior_pixels,
  input  logic             in_half_x,
  input  logic             in_half_y,
  input  logic             in_average_mode,
  input  logic             in_segment,
  input  logic             in_first_row,
  input  logic             in_last_row,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [SEG_W-1:0] out_predicted_pixels,
  output logic             out_segment,
  output logic             out_block_done
);

  localparam int unsigned ADDR_W = (SEGMENTS_PER_ROW > 1) ? $clog2(SEGMENTS_PER_ROW) : 1;

  logic              accept, s1_free;
  logic [ADDR_W-1:0] slot;
  logic [ROW_W-1:0]  cur_row, up_row;
  logic              s1_valid_r, s1_valid_nxt;
  hmc_ctl_t          s1_ctl_r;
  logic [ROW_W-1:0]  s1_cur_r;
  logic [SEG_W-1:0]  s1_prior_r;
  hmc_stage_t        s1;

  assign in_stall = !s1_free;
  assign accept   = in_valid && s1_free;
  assign cur_row  = {in_ref_right, in_ref_pixels};
  assign slot     = (SEGMENTS_PER_ROW > 1) ? ADDR_W'(in_segment) : '0;

  hmc_line_store #(
    .DEPTH  (SEGMENTS_PER_ROW),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .en    (accept),
    .addr  (slot),
    .wdata (cur_row),
    .rdata (up_row)
  );

  always_comb begin
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_free) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cur_r   <= cur_row;
      s1_prior_r <= in_prior_pixels;
      s1_ctl_r   <= '{half_x:       in_half_x,
                      half_y:       in_half_y,
                      average_mode: in_average_mode,
                      segment:      in_segment,
                      first_row:    in_first_row,
                      last_row:     in_last_row};
    end
  end

  assign s1 = '{valid: s1_valid_r, ctl: s1_ctl_r};

  hmc_interp u_interp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .s1                   (s1),
    .cur_row              (s1_cur_r),
    .up_row               (up_row),
    .prior                (s1_prior_r),
    .s1_free              (s1_free),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_predicted_pixels (out_predicted_pixels),
    .out_segment          (out_segment),
    .out_block_done       (out_block_done)
  );

endmodule

// ===== design/hmc_checker.sv =====
// Port-level checks for the half-pel motion compensation predictor, bound to the top level.
`timescale 1ns / 1ps
module hmc_checker import hmc_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic [SEG_W-1:0] in_ref_pixels,
  input logic             in_half_x,
  input logic             in_half_y,
  input logic             in_average_mode,
  input logic             in_first_row,
  input logic             in_last_row,
  input logic             out_valid,
  input logic             out_stall,
  input logic [SEG_W-1:0] out_predicted_pixels,
  input logic             out_block_done
);

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result transaction withdrawn while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_result_due: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_half_y ##1 !out_stall |=> out_valid)
    else $error("result missing two cycles after transaction");

  a_copy_path: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_half_x && !in_half_y && !in_average_mode ##1 !out_stall
    |=> out_predicted_pixels == $past(in_ref_pixels, 2)
        && out_block_done == $past(in_last_row, 2))
    else $error("copy result differs from reference pixels");

  a_first_row_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_half_y && in_first_row ##1 !out_valid |=> !out_valid)
    else $error("vertical first row produced a result");

endmodule

bind halfpel_motion_comp_predict hmc_checker u_hmc_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_stall             (in_stall),
  .in_ref_pixels        (in_ref_pixels),
  .in_half_x            (in_half_x),
  .in_half_y            (in_half_y),
  .in_average_mode      (in_average_mode),
  .in_first_row         (in_first_row),
  .in_last_row          (in_last_row),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_predicted_pixels (out_predicted_pixels),
  .out_block_done       (out_block_done)
);

// ===== tb/halfpel_motion_comp_predict_tb.sv =====
// Self-checking testbench for the half-pel motion compensation predictor.
`timescale 1ns / 1ps
module halfpel_motion_comp_predict_tb;
  import hmc_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES   = 6;
  localparam int unsigned REPORT_CAP     = 50;
  localparam int unsigned NOISE_PCT      = 15;
  localparam int unsigned BROKEN_PCT     = 10;

  typedef struct packed {
    logic [SEG_W-1:0] pixels;
    logic             segment;
    logic             block_done;
  } pred_seg_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [SEG_W-1:0] in_ref_pixels;
  logic [PIX_W-1:0] in_ref_right;
  logic [SEG_W-1:0] in_prior_pixels;
  logic             in_half_x;
  logic             in_half_y;
  logic             in_average_mode;
  logic             in_segment;
  logic             in_first_row;
  logic             in_last_row;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [SEG_W-1:0] out_predicted_pixels;
  logic             out_segment;
  logic             out_block_done;

  pred_seg_t        expected_segs[$];
  logic [ROW_W-1:0] line_store [SEGMENTS_PER_ROW_DEF];
  logic             seg_filled [SEGMENTS_PER_ROW_DEF];
  int unsigned      tx_idle_pct;
  int unsigned      rx_stall_pct;
  int unsigned      mismatches = 0;
  int unsigned      quiet_cycles = 0;

  halfpel_motion_comp_predict i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_ref_pixels        (in_ref_pixels),
    .in_ref_right         (in_ref_right),
    .in_prior_pixels      (in_prior_pixels),
    .in_half_x            (in_half_x),
    .in_half_y            (in_half_y),
    .in_average_mode      (in_average_mode),
    .in_segment           (in_segment),
    .in_first_row         (in_first_row),
    .in_last_row          (in_last_row),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_predicted_pixels (out_predicted_pixels),
    .out_segment          (out_segment),
    .out_block_done       (out_block_done)
  );

  always #4 clk = ~clk;

  function automatic logic [SEG_W-1:0] interpolate(input logic [ROW_W-1:0] cur,
                                                   input logic [ROW_W-1:0] up,
                                                   input logic [SEG_W-1:0] prior,
                                                   input hmc_ctl_t c);
    logic [SEG_W-1:0] res;
    logic [9:0]       a;
    logic [9:0]       b;
    logic [9:0]       u0;
    logic [9:0]       u1;
    logic [9:0]       p;
    res = '0;
    for (int i = 0; i < LANES; i++) begin
      a  = 10'(cur[i*PIX_W +: PIX_W]);
      b  = 10'(cur[(i+1)*PIX_W +: PIX_W]);
      u0 = 10'(up[i*PIX_W +: PIX_W]);
      u1 = 10'(up[(i+1)*PIX_W +: PIX_W]);
      if (c.half_x && c.half_y) begin
        p = (u0 + u1 + a + b + 10'd2) >> 2;
      end else if (c.half_y) begin
        p = (u0 + a + 10'd1) >> 1;
      end else if (c.half_x) begin
        p = (a + b + 10'd1) >> 1;
      end else begin
        p = a;
      end
      if (c.average_mode) begin
        p = (p + 10'(prior[i*PIX_W +: PIX_W]) + 10'd1) >> 1;
      end
      res[i*PIX_W +: PIX_W] = p[PIX_W-1:0];
    end
    return res;
  endfunction

  function automatic hmc_ctl_t ctl_of(input logic hx, input logic hy, input logic avg,
                                      input logic seg, input logic first, input logic last);
    hmc_ctl_t c;
    c.half_x       = hx;
    c.half_y       = hy;
    c.average_mode = avg;
    c.segment      = seg;
    c.first_row    = first;
    c.last_row     = last;
    return c;
  endfunction

  function automatic logic [SEG_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic report_mismatch(input string what, input logic [SEG_W-1:0] got,
                                 input logic [SEG_W-1:0] want);
    if (mismatches < REPORT_CAP) begin
      $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  task automatic send_segment(input logic [SEG_W-1:0] ref_px, input logic [PIX_W-1:0] right,
                              input logic [SEG_W-1:0] prior, input hmc_ctl_t c);
    logic [ROW_W-1:0] cur_row;
    int unsigned      slot;
    pred_seg_t        want;
    slot = c.segment % SEGMENTS_PER_ROW_DEF;
    // never read a line store entry that has not been filled since reset
    if (c.half_y && !c.first_row && !seg_filled[slot]) begin
      c.first_row = 1'b1;
    end
    cur_row         = {right, ref_px};
    in_ref_pixels   <= ref_px;
    in_ref_right    <= right;
    in_prior_pixels <= prior;
    in_half_x       <= c.half_x;
    in_half_y       <= c.half_y;
    in_average_mode <= c.average_mode;
    in_segment      <= c.segment;
    in_first_row    <= c.first_row;
    in_last_row     <= c.last_row;
    in_valid        <= 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (!(c.half_y && c.first_row)) begin
      want.pixels     = interpolate(cur_row, line_store[slot], prior, c);
      want.segment    = c.segment;
      want.block_done = c.last_row;
      expected_segs.push_back(want);
    end
    line_store[slot] = cur_row;
    seg_filled[slot] = 1'b1;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic test_copy_and_horizontal();
    send_segment('0, 8'h00, '0, ctl_of(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
    send_segment('1, 8'hFF, '0, ctl_of(1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0));
    send_segment('1, 8'h00, '0, ctl_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_segment(64'h00FF00FF00FF00FF, 8'h01, '0,
                 ctl_of(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
    send_segment(64'h0123456789ABCDEF, 8'h5A, '1,
                 ctl_of(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    send_segment(64'hFEDCBA9876543210, 8'hA5, '0,
                 ctl_of(1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1));
  endtask

  task automatic test_vertical_rows();
    send_segment('1, 8'hFF, '0, ctl_of(1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0));
    send_segment('0, 8'h00, '0, ctl_of(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    send_segment(64'h0101010101010101, 8'h01, '0,
                 ctl_of(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
    send_segment(64'h0101010101010101, 8'h01, '0,
                 ctl_of(1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0));
    send_segment(64'h0001000100010001, 8'h00, '0,
                 ctl_of(1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0));
    send_segment('1, 8'hFF, '0, ctl_of(1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1));
    // first and last row at once: the block end marker is dropped
    send_segment(rand_word(), 8'($urandom), rand_word(),
                 ctl_of(1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1));
    send_segment(rand_word(), 8'($urandom), rand_word(),
                 ctl_of(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
  endtask

  task automatic test_average_mode();
    send_segment('0, 8'h00, '1, ctl_of(1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0));
    send_segment('1, 8'hFF, '0, ctl_of(1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0));
    send_segment('1, 8'hFF, '1, ctl_of(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
    send_segment('0, 8'h00, '0, ctl_of(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0));
    send_segment(rand_word(), 8'($urandom), rand_word(),
                 ctl_of(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1));
  endtask

  task automatic test_random_blocks(input int unsigned n_items);
    int unsigned sent;
    int unsigned rows;
    int unsigned cut;
    logic        hx;
    logic        hy;
    logic        avg;
    logic        both_halves;
    logic        seg_pick;
    hmc_ctl_t    c;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < NOISE_PCT) begin
        c = hmc_ctl_t'(6'($urandom_range(63)));
        send_segment(rand_word(), 8'($urandom), rand_word(), c);
        sent++;
      end else begin
        hx          = 1'($urandom_range(1));
        hy          = 1'($urandom_range(1));
        avg         = 1'($urandom_range(1));
        both_halves = 1'($urandom_range(1));
        seg_pick    = 1'($urandom_range(1));
        rows        = $urandom_range(2, 17);
        cut         = ($urandom_range(99) < BROKEN_PCT) ? $urandom_range(1, rows - 1) : rows;
        for (int r = 0; r < cut; r++) begin
          for (int s = 0; s < (both_halves ? 2 : 1); s++) begin
            c = ctl_of(hx, hy, avg, both_halves ? 1'(s) : seg_pick, r == 0, r == rows - 1);
            send_segment(rand_word(), 8'($urandom), rand_word(), c);
            sent++;
          end
        end
      end
    end
  endtask

  always @(posedge clk) begin
    pred_seg_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_segs.size() == 0) begin
        report_mismatch("result with no pending prediction", out_predicted_pixels, '0);
      end else begin
        want = expected_segs.pop_front();
        if (out_predicted_pixels !== want.pixels) begin
          report_mismatch("predicted_pixels", out_predicted_pixels, want.pixels);
        end
        if (out_segment !== want.segment) begin
          report_mismatch("segment", SEG_W'(out_segment), SEG_W'(want.segment));
        end
        if (out_block_done !== want.block_done) begin
          report_mismatch("block_done", SEG_W'(out_block_done), SEG_W'(want.block_done));
        end
      end
    end
    out_stall <= (rx_stall_pct != 0) && ($urandom_range(99) < rx_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_ref_pixels   = '0;
    in_ref_right    = '0;
    in_prior_pixels = '0;
    in_half_x       = 1'b0;
    in_half_y       = 1'b0;
    in_average_mode = 1'b0;
    in_segment      = 1'b0;
    in_first_row    = 1'b0;
    in_last_row     = 1'b0;
    tx_idle_pct     = 19;
    rx_stall_pct    = 68;
    for (int s = 0; s < SEGMENTS_PER_ROW_DEF; s++) begin
      line_store[s] = '0;
      seg_filled[s] = 1'b0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_copy_and_horizontal();
    test_vertical_rows();
    test_average_mode();
    test_random_blocks(580);
    tx_idle_pct  = 68;
    rx_stall_pct = 19;
    test_random_blocks(580);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    test_random_blocks(590);
    in_valid <= 1'b0;

    while (expected_segs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
